// ----- rtl/pcfe_pkg.sv -----
// Shared types and constants for the predictive coding free energy engine.
package pcfe_pkg;

  localparam int WORD_W     = 32;
  localparam int CFG_AW     = 2;
  localparam int DIV_STAGES = 2;
  localparam int MUL_STAGES = 2;
  localparam int CTL_DEPTH  = DIV_STAGES + MUL_STAGES;
  localparam int Q_SHIFT    = 16;

  localparam logic [CFG_AW-1:0] REG_LEVEL0_PRECISION = 2'd0;
  localparam logic [CFG_AW-1:0] REG_LEVEL1_PRECISION = 2'd1;
  localparam logic [CFG_AW-1:0] REG_LEVEL2_PRECISION = 2'd2;
  localparam logic [CFG_AW-1:0] REG_ENERGY_CEILING   = 2'd3;

  localparam logic [WORD_W-1:0] LEVEL0_PRECISION_RST = 32'h0001_0000;
  localparam logic [WORD_W-1:0] LEVEL1_PRECISION_RST = 32'h0000_8000;
  localparam logic [WORD_W-1:0] LEVEL2_PRECISION_RST = 32'h0000_4000;
  localparam logic [WORD_W-1:0] ENERGY_CEILING_RST   = 32'h0008_0000;

  localparam logic ACT_ELEMENT = 1'b0;
  localparam logic ACT_CLEAR   = 1'b1;

  typedef struct packed {
    logic signed [WORD_W-1:0] level0;
    logic signed [WORD_W-1:0] level1;
    logic signed [WORD_W-1:0] level2;
  } pcfe_prec_t;

  typedef struct packed {
    logic              valid;
    logic              clear;
    logic              done;
    logic [WORD_W-1:0] mean;
  } pcfe_ctl_t;

endpackage

// ----- rtl/pcfe_belief_mem.sv -----
// Middle belief memory: one write port, one registered read port with write bypass.
module pcfe_belief_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [pcfe_pkg::WORD_W-1:0] rdata,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [pcfe_pkg::WORD_W-1:0] wdata
);

  logic [pcfe_pkg::WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else if (valid[raddr]) begin
        rdata <= mem[raddr];
      end else begin
        rdata <= '0;
      end
    end
  end

endmodule

// ----- rtl/pcfe_div.sv -----
// Two-stage division of a 32-bit value by the constant DIM through a reciprocal multiply.
module pcfe_div #(
  parameter int DIM = 16
) (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [pcfe_pkg::WORD_W-1:0] num_in,
  output logic [pcfe_pkg::WORD_W-1:0] quo
);

  localparam int W     = pcfe_pkg::WORD_W;
  localparam int SHIFT = $clog2(DIM);
  localparam int RW    = W + 1;
  localparam logic [W:0] RECIP =
    RW'(((65'd1 << (W + SHIFT)) / 65'(DIM)) + 65'd1);

  logic [2*W-1:0] prod;
  logic [W-1:0]   num_hi;
  logic [2*W:0]   full;

  assign full = {1'b0, prod} + {1'b0, num_hi, {W{1'b0}}};

  always_ff @(posedge clk) begin
    if (adv) begin
      prod   <= num_in * RECIP[W-1:0];
      num_hi <= RECIP[W] ? num_in : '0;
      quo    <= W'(full >> (W + SHIFT));
    end
  end

endmodule

// ----- rtl/pcfe_energy.sv -----
// Precision-weighted Q16 products of the mean errors and their wrapping sum.
module pcfe_energy (
  input  logic                        clk,
  input  logic                        adv,
  input  pcfe_pkg::pcfe_prec_t        prec,
  input  logic [pcfe_pkg::WORD_W-1:0] mean_abs,
  input  logic [pcfe_pkg::WORD_W-1:0] mean_half,
  output logic [pcfe_pkg::WORD_W-1:0] energy
);

  logic signed [2*pcfe_pkg::WORD_W-1:0] prod0;
  logic signed [2*pcfe_pkg::WORD_W-1:0] prod1;
  logic signed [2*pcfe_pkg::WORD_W-1:0] prod2;
  logic [pcfe_pkg::WORD_W-1:0]          q0;
  logic [pcfe_pkg::WORD_W-1:0]          q1;
  logic [pcfe_pkg::WORD_W-1:0]          q2;

  assign prod0 = prec.level0 * $signed(mean_abs);
  assign prod1 = prec.level1 * $signed(mean_half);
  assign prod2 = prec.level2 * $signed(mean_half);

  always_ff @(posedge clk) begin
    if (adv) begin
      q0     <= prod0[pcfe_pkg::Q_SHIFT +: pcfe_pkg::WORD_W];
      q1     <= prod1[pcfe_pkg::Q_SHIFT +: pcfe_pkg::WORD_W];
      q2     <= prod2[pcfe_pkg::Q_SHIFT +: pcfe_pkg::WORD_W];
      energy <= q0 + q1 + q2;
    end
  end

endmodule

// ----- rtl/predictive_coding_free_energy.sv -----
// Top level of the predictive coding free energy engine.
// Path: an item passes stage 1, stage 2, the divider and energy stages, then the output register.
// Throughput: one item per cycle while m_tready does not stall the output; the belief memory does
// one read and one write per cycle, with a write bypass for back-to-back hits on the same entry.
// Reset: synchronous; beliefs read as zero through per-entry valid bits, no
// clearing pass, and the block accepts items in the cycle after reset drops.
module predictive_coding_free_energy #(
  parameter int DIM = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,   // obs, prior
  input  logic                          s_tuser,   // action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [103:0]                  m_tdata,   // level0_mean, step_energy, total_energy, energy_ok, zero fill
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [pcfe_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [pcfe_pkg::WORD_W-1:0]   cfg_wdata
);

  localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DIM - 1);

  logic                        adv;
  logic                        accept;
  pcfe_pkg::pcfe_prec_t        prec;
  logic [pcfe_pkg::WORD_W-1:0] energy_ceiling;

  logic [AW-1:0]               element_index;

  logic                        v1;
  logic                        act1;
  logic [AW-1:0]               idx1;
  logic [pcfe_pkg::WORD_W-1:0] obs1;
  logic [pcfe_pkg::WORD_W-1:0] prior1;
  logic [pcfe_pkg::WORD_W-1:0] old1;

  logic [pcfe_pkg::WORD_W-1:0] err;
  logic [pcfe_pkg::WORD_W-1:0] half;
  logic [pcfe_pkg::WORD_W-1:0] mean;
  logic [pcfe_pkg::WORD_W-1:0] belief_next;
  logic [pcfe_pkg::WORD_W-1:0] abs_sum_next;
  logic [pcfe_pkg::WORD_W-1:0] half_sum_next;
  logic                        elem1;
  logic                        last1;

  logic [pcfe_pkg::WORD_W-1:0] abs_error_sum;
  logic [pcfe_pkg::WORD_W-1:0] half_error_sum;

  pcfe_pkg::pcfe_ctl_t         ctl2;
  logic [pcfe_pkg::WORD_W-1:0] sum_abs2;
  logic [pcfe_pkg::WORD_W-1:0] sum_half2;
  pcfe_pkg::pcfe_ctl_t         ctl [pcfe_pkg::CTL_DEPTH];
  pcfe_pkg::pcfe_ctl_t         ctl_out;

  logic [pcfe_pkg::WORD_W-1:0] mean_abs;
  logic [pcfe_pkg::WORD_W-1:0] mean_half;
  logic [pcfe_pkg::WORD_W-1:0] energy;

  logic [pcfe_pkg::WORD_W-1:0] running_total;
  logic [pcfe_pkg::WORD_W-1:0] last_energy;
  logic [pcfe_pkg::WORD_W-1:0] running_total_next;
  logic [pcfe_pkg::WORD_W-1:0] last_energy_next;

  logic                        o_valid;
  logic                        o_done;
  logic [pcfe_pkg::WORD_W-1:0] o_mean;
  logic [pcfe_pkg::WORD_W-1:0] o_energy;
  logic [pcfe_pkg::WORD_W-1:0] o_total;
  logic                        o_ok;

  function automatic logic [pcfe_pkg::WORD_W-1:0] half_trunc(
    input logic [pcfe_pkg::WORD_W-1:0] u
  );
    logic [pcfe_pkg::WORD_W-1:0] t;
    t = u + {{(pcfe_pkg::WORD_W-1){1'b0}}, u[pcfe_pkg::WORD_W-1]};
    return {t[pcfe_pkg::WORD_W-1], t[pcfe_pkg::WORD_W-1:1]};
  endfunction

  function automatic logic [pcfe_pkg::WORD_W-1:0] abs_word(
    input logic [pcfe_pkg::WORD_W-1:0] u
  );
    return u[pcfe_pkg::WORD_W-1] ? (~u + 1'b1) : u;
  endfunction

  assign adv      = !o_valid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      prec.level0    <= pcfe_pkg::LEVEL0_PRECISION_RST;
      prec.level1    <= pcfe_pkg::LEVEL1_PRECISION_RST;
      prec.level2    <= pcfe_pkg::LEVEL2_PRECISION_RST;
      energy_ceiling <= pcfe_pkg::ENERGY_CEILING_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        pcfe_pkg::REG_LEVEL0_PRECISION: prec.level0    <= cfg_wdata;
        pcfe_pkg::REG_LEVEL1_PRECISION: prec.level1    <= cfg_wdata;
        pcfe_pkg::REG_LEVEL2_PRECISION: prec.level2    <= cfg_wdata;
        pcfe_pkg::REG_ENERGY_CEILING:   energy_ceiling <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // element index
  always_ff @(posedge clk) begin
    if (rst) begin
      element_index <= '0;
    end else if (accept && (s_tuser == pcfe_pkg::ACT_ELEMENT)) begin
      element_index <= (element_index == LAST_IDX) ? '0 : element_index + 1'b1;
    end
  end

  // stage 1: memory read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act1   <= s_tuser;
      idx1   <= element_index;
      obs1   <= s_tdata[31:0];
      prior1 <= s_tdata[63:32];
    end
  end

  pcfe_belief_mem #(
    .DEPTH (DIM),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .re    (adv),
    .raddr (element_index),
    .rdata (old1),
    .we    (adv && elem1),
    .waddr (idx1),
    .wdata (belief_next)
  );

  assign elem1         = v1 && (act1 == pcfe_pkg::ACT_ELEMENT);
  assign last1         = idx1 == LAST_IDX;
  assign err           = obs1 - old1;
  assign half          = half_trunc(err);
  assign mean          = half_trunc(obs1 + old1);
  assign belief_next   = prior1 + half;
  assign abs_sum_next  = abs_error_sum + abs_word(err);
  assign half_sum_next = half_error_sum + abs_word(half);

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_error_sum  <= '0;
      half_error_sum <= '0;
    end else if (adv && elem1) begin
      abs_error_sum  <= last1 ? '0 : abs_sum_next;
      half_error_sum <= last1 ? '0 : half_sum_next;
    end
  end

  // stage 2: step sums and per-element results
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2.valid <= 1'b0;
    end else if (adv) begin
      ctl2.valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl2.clear <= act1;
      ctl2.done  <= elem1 && last1;
      ctl2.mean  <= elem1 ? mean : '0;
      sum_abs2   <= abs_sum_next;
      sum_half2  <= half_sum_next;
    end
  end

  // control delay line alongside divider and multipliers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < pcfe_pkg::CTL_DEPTH; s++) begin
        ctl[s].valid <= 1'b0;
      end
    end else if (adv) begin
      ctl[0] <= ctl2;
      for (int s = 1; s < pcfe_pkg::CTL_DEPTH; s++) begin
        ctl[s] <= ctl[s-1];
      end
    end
  end

  assign ctl_out = ctl[pcfe_pkg::CTL_DEPTH-1];

  pcfe_div #(.DIM(DIM)) u_div_abs (
    .clk    (clk),
    .adv    (adv),
    .num_in (sum_abs2),
    .quo    (mean_abs)
  );

  pcfe_div #(.DIM(DIM)) u_div_half (
    .clk    (clk),
    .adv    (adv),
    .num_in (sum_half2),
    .quo    (mean_half)
  );

  pcfe_energy u_energy (
    .clk       (clk),
    .adv       (adv),
    .prec      (prec),
    .mean_abs  (mean_abs),
    .mean_half (mean_half),
    .energy    (energy)
  );

  // output stage: running total and ceiling gate
  always_comb begin
    running_total_next = running_total;
    last_energy_next   = last_energy;
    if (ctl_out.valid) begin
      if (ctl_out.clear == pcfe_pkg::ACT_CLEAR) begin
        running_total_next = '0;
      end else if (ctl_out.done) begin
        running_total_next = running_total + energy;
        last_energy_next   = energy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid       <= 1'b0;
      running_total <= '0;
      last_energy   <= '0;
    end else if (adv) begin
      o_valid       <= ctl_out.valid;
      running_total <= running_total_next;
      last_energy   <= last_energy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_mean   <= ctl_out.mean;
      o_done   <= ctl_out.done;
      o_energy <= ctl_out.done ? energy : '0;
      o_total  <= running_total_next;
      o_ok     <= last_energy_next <= energy_ceiling;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tlast  = o_done;
  assign m_tdata  = {7'd0, o_ok, o_total, o_energy, o_mean};

endmodule

// ----- test/predictive_coding_free_energy_tb.sv -----
// Self-checking testbench for the predictive coding free energy engine.
module predictive_coding_free_energy_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ELEMS          = 16;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          SETTLE_CYCLES  = 16;
  localparam int          MAX_REPORTS    = 10;

  localparam logic [pcfe_pkg::CFG_AW-1:0] REG_ORDER [4] = '{
    pcfe_pkg::REG_LEVEL0_PRECISION, pcfe_pkg::REG_LEVEL1_PRECISION,
    pcfe_pkg::REG_LEVEL2_PRECISION, pcfe_pkg::REG_ENERGY_CEILING
  };

  localparam logic [31:0] DIR_OBS [ELEMS] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_0000,
    32'h8001_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_8000,
    32'hFFFF_8000, 32'h1234_5678, 32'hEDCB_A987, 32'h7FFF_FFFF
  };
  localparam logic [31:0] DIR_PRIOR [ELEMS] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_0000,
    32'h0001_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_8000,
    32'h0000_8000, 32'hEDCB_A987, 32'h1234_5678, 32'h8000_0000
  };

  typedef struct packed {
    logic [31:0] mean;
    logic        done;
    logic [31:0] energy;
    logic [31:0] total;
    logic        ok;
  } energy_result_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          s_tvalid  = 1'b0;
  logic          s_tready;
  logic [63:0]   s_tdata   = '0;
  logic          s_tuser   = pcfe_pkg::ACT_ELEMENT;
  logic          m_tvalid;
  logic          m_tready  = 1'b0;
  logic [103:0]  m_tdata;
  logic          m_tlast;
  logic          cfg_we    = 1'b0;
  logic [pcfe_pkg::CFG_AW-1:0] cfg_addr  = '0;
  logic [pcfe_pkg::WORD_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [31:0] belief_mem [ELEMS];
  int unsigned elem_idx;
  logic [31:0] abs_sum;
  logic [31:0] half_sum;
  logic [31:0] total_acc;
  logic [31:0] last_f;
  logic [31:0] prec0;
  logic [31:0] prec1;
  logic [31:0] prec2;
  logic [31:0] ceiling;

  energy_result_t predicted_q [$];
  int  mismatch_cnt = 0;
  int  idle_cycles  = 0;
  bit  tx_idle_en   = 1'b1;
  bit  rx_idle_en   = 1'b1;
  int  rx_hold_len  = 0;
  int  rx_hold_cnt  = 0;
  int  rx_gap       = 0;

  always #5 clk = ~clk;

  predictive_coding_free_energy #(.DIM(ELEMS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  function automatic logic [31:0] halve_trunc(logic [31:0] u);
    logic [31:0] t;
    t = u + {31'b0, u[31]};
    return {t[31], t[31:1]};
  endfunction

  function automatic logic [31:0] abs_word(logic [31:0] u);
    return u[31] ? (32'd0 - u) : u;
  endfunction

  function automatic logic [31:0] q16_mul(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] ax;
    logic signed [63:0] bx;
    logic signed [63:0] p;
    ax = $signed(a);
    bx = $signed(b);
    p  = ax * bx;
    return p[47:16];
  endfunction

  function automatic energy_result_t predict_free_energy(logic act, logic [31:0] obs,
                                                        logic [31:0] prior);
    energy_result_t res;
    int unsigned    idx;
    logic [31:0]    old;
    logic [31:0]    err;
    logic [31:0]    half;
    logic [31:0]    f;
    res = '0;
    if (act == pcfe_pkg::ACT_CLEAR) begin
      total_acc = '0;
    end else begin
      idx             = elem_idx;
      old             = belief_mem[idx];
      err             = obs - old;
      half            = halve_trunc(err);
      res.mean        = halve_trunc(obs + old);
      belief_mem[idx] = prior + half;
      abs_sum         = abs_sum + abs_word(err);
      half_sum        = half_sum + abs_word(half);
      if (idx == ELEMS - 1) begin
        f = q16_mul(prec0, abs_sum / ELEMS) + q16_mul(prec1, half_sum / ELEMS)
          + q16_mul(prec2, half_sum / ELEMS);
        total_acc  = total_acc + f;
        last_f     = f;
        abs_sum    = '0;
        half_sum   = '0;
        elem_idx   = 0;
        res.done   = 1'b1;
        res.energy = f;
      end else begin
        elem_idx = idx + 1;
      end
    end
    res.total = total_acc;
    res.ok    = (last_f <= ceiling);
    return res;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  // receiver: random stalls plus an on-demand long hold
  always @(posedge clk) begin
    if (rx_hold_len > 0) begin
      rx_hold_cnt = rx_hold_len;
      rx_hold_len = 0;
    end
    if (rx_hold_cnt > 0) begin
      rx_hold_cnt = rx_hold_cnt - 1;
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      m_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
      rx_gap = $urandom_range(0, 17);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // sample at the falling edge: values here are what the next rising edge transfers
  always @(negedge clk) begin
    energy_result_t got;
    energy_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.mean   = m_tdata[31:0];
      got.done   = m_tlast;
      got.energy = m_tdata[63:32];
      got.total  = m_tdata[95:64];
      got.ok     = m_tdata[96];
      if (predicted_q.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result: mean=%h done=%b energy=%h total=%h ok=%b",
                   got.mean, got.done, got.energy, got.total, got.ok);
      end else begin
        want = predicted_q.pop_front();
        if (got.mean !== want.mean || got.done !== want.done ||
            got.energy !== want.energy || got.total !== want.total ||
            got.ok !== want.ok) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= MAX_REPORTS)
            $display({"mismatch: exp mean=%h done=%b energy=%h total=%h ok=%b",
                      " | got mean=%h done=%b energy=%h total=%h ok=%b"},
                     want.mean, want.done, want.energy, want.total, want.ok,
                     got.mean, got.done, got.energy, got.total, got.ok);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(logic act, logic [31:0] obs, logic [31:0] prior);
    int gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {prior, obs};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    predicted_q.push_back(predict_free_energy(act, obs, prior));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] p0, logic [31:0] p1, logic [31:0] p2,
                            logic [31:0] ceil);
    logic [31:0] vals [4];
    drain_results();
    vals = '{p0, p1, p2, ceil};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= REG_ORDER[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    prec0   = p0;
    prec1   = p1;
    prec2   = p2;
    ceiling = ceil;
  endtask

  task automatic send_random_element();
    send_item(pcfe_pkg::ACT_ELEMENT, rand_word(), rand_word());
  endtask

  task automatic test_directed_extremes();
    send_item(pcfe_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < ELEMS; i++) begin
      if (i == 7) send_item(pcfe_pkg::ACT_CLEAR, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(pcfe_pkg::ACT_ELEMENT, DIR_OBS[i], DIR_PRIOR[i]);
    end
    send_item(pcfe_pkg::ACT_CLEAR, 32'h0000_0000, 32'h0000_0000);
    send_item(pcfe_pkg::ACT_ELEMENT, 32'h7FFF_FFFF, 32'h0000_0000);
    send_item(pcfe_pkg::ACT_ELEMENT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(pcfe_pkg::ACT_ELEMENT, 32'h0000_0000, 32'h7FFF_FFFF);
    send_item(pcfe_pkg::ACT_ELEMENT, 32'hFFFF_FFFF, 32'h8000_0000);
  endtask

  task automatic test_config_sweep();
    for (int s = 0; s < 5; s++) begin
      case (s)
        0: set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        1: set_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
        2: set_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        3: set_config(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        default: set_config($urandom, $urandom, $urandom, $urandom);
      endcase
      for (int i = 0; i < 3 * ELEMS; i++) send_random_element();
    end
  endtask

  task automatic test_random_steps();
    for (int c = 0; c < 3; c++) begin
      if (c == 0)
        set_config(pcfe_pkg::LEVEL0_PRECISION_RST, pcfe_pkg::LEVEL1_PRECISION_RST,
                   pcfe_pkg::LEVEL2_PRECISION_RST, pcfe_pkg::ENERGY_CEILING_RST);
      else
        set_config(rand_word(), rand_word(), rand_word(),
                   ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000));
      for (int i = 0; i < 300; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_item(pcfe_pkg::ACT_CLEAR, $urandom, $urandom);
        else
          send_random_element();
      end
    end
  endtask

  task automatic test_output_backpressure();
    tx_idle_en  = 1'b0;
    rx_hold_len = 300;
    for (int i = 0; i < 80; i++) send_random_element();
    drain_results();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_streaming_no_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < 200; i++) begin
      if ($urandom_range(0, 29) == 0)
        send_item(pcfe_pkg::ACT_CLEAR, $urandom, $urandom);
      else
        send_random_element();
    end
  endtask

  initial begin
    for (int i = 0; i < ELEMS; i++) belief_mem[i] = '0;
    elem_idx  = 0;
    abs_sum   = '0;
    half_sum  = '0;
    total_acc = '0;
    last_f    = '0;
    prec0     = pcfe_pkg::LEVEL0_PRECISION_RST;
    prec1     = pcfe_pkg::LEVEL1_PRECISION_RST;
    prec2     = pcfe_pkg::LEVEL2_PRECISION_RST;
    ceiling   = pcfe_pkg::ENERGY_CEILING_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_config_sweep();
    test_random_steps();
    test_output_backpressure();
    test_streaming_no_idle();
    drain_results();
    if (mismatch_cnt == 0 && predicted_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pcfe_pkg.sv
rtl/pcfe_belief_mem.sv
rtl/pcfe_div.sv
rtl/pcfe_energy.sv
rtl/predictive_coding_free_energy.sv
test/predictive_coding_free_energy_tb.sv
